@@ rtl/ims_pkg.sv @@
// ims_pkg: shared sizes, types and codes for the interleaved multi-stack core.
// No dependencies; imported by ims_store and interleaved_multi_stack_core.

package ims_pkg;

  // Stack organization
  localparam int unsigned NumStacks = 8;
  localparam int unsigned Depth     = 16;
  localparam int unsigned Entries   = NumStacks * Depth;

  // Fixed port field widths
  localparam int unsigned DataW    = 32;
  localparam int unsigned SidPortW = 4;
  localparam int unsigned SpcPortW = 5;
  localparam int unsigned LenPortW = 5;
  localparam int unsigned UsePortW = 4;

  // Derived internal widths
  localparam int unsigned AddrW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned StkW  = (NumStacks > 1) ? $clog2(NumStacks) : 1;
  localparam int unsigned LenW  = $clog2(Depth + 1);
  localparam int unsigned UseW  = $clog2(NumStacks + 1);
  localparam int unsigned SumW  = ((LenW > SpcPortW) ? LenW : SpcPortW) + 1;

  typedef logic [DataW-1:0] data_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [StkW-1:0]  stk_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [UseW-1:0]  use_t;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_STATUS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_STACK = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

@@ rtl/ims_store.sv @@
// ims_store: item store shared by all stacks, one write and one read port,
// registered read data. Depends on ims_pkg.

module ims_store
  import ims_pkg::*;
(
  input  logic  clk_i,
  input  logic  we_i,
  input  addr_t waddr_i,
  input  data_t wdata_i,
  input  logic  re_i,
  input  addr_t raddr_i,
  output data_t rdata_o
);

  data_t mem_q [Entries];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/interleaved_multi_stack_core.sv @@
// interleaved_multi_stack_core: NumStacks stacks interleaved in one item store.
// Depends on ims_pkg and ims_store.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  request   | start_i / busy_o     | mode_i, stack_id_i, push_value_i, space_count_i
//  result    | done_o (1-cycle)     | status_o, read_value_o, stack_length_o,
//            |                      | space_ok_o, stacks_in_use_o
//
// One request per cycle; busy_o stays low. The result strobes in the cycle after
// the request beat, a delay set by the store's registered read port.
// Lengths and the in-use count update at the request beat, so a following
// request sees them at once; store reads and writes never touch the same
// beat, so no forwarding is needed. Reset clears all lengths immediately;
// there is no clearing pass. The receiver cannot stall results.

module interleaved_multi_stack_core
  import ims_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          mode_i,
  input  logic [SidPortW-1:0] stack_id_i,
  input  logic signed [DataW-1:0] push_value_i,
  input  logic [SpcPortW-1:0] space_count_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic signed [DataW-1:0] read_value_o,
  output logic [LenPortW-1:0] stack_length_o,
  output logic                space_ok_o,
  output logic [UsePortW-1:0] stacks_in_use_o
);

  len_t    len_q [NumStacks];
  use_t    inuse_q, inuse_d;
  logic    done_q;
  logic    rd_q;
  status_e status_q, status_d;
  len_t    len_out_q, len_new;
  logic    space_q, space_d;

  logic    accept, sid_ok, wr_en, rd_en, len_we;
  stk_t    sidx;
  len_t    len_cur, len_m1;
  addr_t   wr_addr, rd_addr;
  data_t   rdata;
  logic [SumW-1:0] room_sum;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign sid_ok  = ({1'b0, stack_id_i} < (SidPortW + 1)'(NumStacks));
  assign sidx    = stk_t'(stack_id_i);
  assign len_cur = sid_ok ? len_q[sidx] : '0;
  assign len_m1  = len_cur - len_t'(1);

  // entry i of stack n sits at i*NumStacks + n
  assign wr_addr = addr_t'(len_cur) * addr_t'(NumStacks) + addr_t'(sidx);
  assign rd_addr = addr_t'(len_m1) * addr_t'(NumStacks) + addr_t'(sidx);

  always_comb begin
    status_d = ST_OK;
    len_new  = len_cur;
    inuse_d  = inuse_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    len_we   = 1'b0;
    if (!sid_ok) begin
      status_d = ST_NO_STACK;
    end else begin
      case (mode_e'(mode_i))
        MODE_PUSH: begin
          if (len_cur == len_t'(Depth)) begin
            status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            len_we  = 1'b1;
            len_new = len_cur + len_t'(1);
            if (len_cur == '0) begin
              inuse_d = inuse_q + use_t'(1);
            end
          end
        end
        MODE_POP: begin
          if (len_cur == '0) begin
            status_d = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            len_we  = 1'b1;
            len_new = len_m1;
            if (len_m1 == '0) begin
              inuse_d = inuse_q - use_t'(1);
            end
          end
        end
        MODE_PEEK: begin
          if (len_cur == '0) begin
            status_d = ST_EMPTY;
          end else begin
            rd_en = 1'b1;
          end
        end
        MODE_STATUS: begin
          status_d = ST_OK;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  assign room_sum = SumW'(len_new) + SumW'(space_count_i);
  assign space_d  = sid_ok && (room_sum <= SumW'(Depth));

  ims_store u_store (
    .clk_i   (clk_i),
    .we_i    (accept && wr_en),
    .waddr_i (wr_addr),
    .wdata_i (data_t'(push_value_i)),
    .re_i    (accept && rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStacks; i++) begin
        len_q[i] <= '0;
      end
      inuse_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        inuse_q <= inuse_d;
        if (len_we) begin
          len_q[sidx] <= len_new;
        end
      end
    end
  end

  // result payload, only meaningful while done_o is high
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      len_out_q <= len_new;
      space_q   <= space_d;
      rd_q      <= rd_en;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_value_o    = rd_q ? $signed(rdata) : '0;
  assign stack_length_o  = LenPortW'(len_out_q);
  assign space_ok_o      = space_q;
  assign stacks_in_use_o = UsePortW'(inuse_q);

endmodule

@@ bench/interleaved_multi_stack_core_test.sv @@
// Self-checking bench for interleaved_multi_stack_core: directed and random
// requests with random gaps, each result checked against a built-in stack model.
// Depends on ims_pkg and the core RTL.
`timescale 1ns / 1ps

module interleaved_multi_stack_core_test;
  import ims_pkg::*;

  localparam int unsigned IdleLimit   = 400;
  localparam int unsigned TailCycles  = 8;
  localparam int unsigned RandomBeats = 600;

  typedef struct {
    mode_e                   mode;
    logic [SidPortW-1:0]     sid;
    logic signed [DataW-1:0] value;
    logic [SpcPortW-1:0]     cnt;
    int                      gap;
    bit                      drain;
  } stack_req_t;

  typedef struct {
    status_e                 status;
    logic signed [DataW-1:0] rdval;
    logic [LenPortW-1:0]     len;
    logic                    space;
    logic [UsePortW-1:0]     in_use;
  } stack_reply_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic [1:0]              mode_i = '0;
  logic [SidPortW-1:0]     stack_id_i = '0;
  logic signed [DataW-1:0] push_value_i = '0;
  logic [SpcPortW-1:0]     space_count_i = '0;
  logic                    done_o;
  logic [1:0]              status_o;
  logic signed [DataW-1:0] read_value_o;
  logic [LenPortW-1:0]     stack_length_o;
  logic                    space_ok_o;
  logic [UsePortW-1:0]     stacks_in_use_o;

  interleaved_multi_stack_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .mode_i          (mode_i),
    .stack_id_i      (stack_id_i),
    .push_value_i    (push_value_i),
    .space_count_i   (space_count_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .stack_length_o  (stack_length_o),
    .space_ok_o      (space_ok_o),
    .stacks_in_use_o (stacks_in_use_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state
  logic signed [DataW-1:0] model_items [NumStacks*Depth];
  int                      model_len [NumStacks];
  int                      model_in_use;

  stack_req_t   request_q [$];
  stack_reply_t replies_due [$];
  stack_req_t   drive_req;
  stack_reply_t due_reply;
  int           fail_count;
  int           idle_run;
  int           quiet_cycles;
  int           beats_made;

  function automatic stack_reply_t stack_step(mode_e mode, logic [SidPortW-1:0] sid,
                                              logic signed [DataW-1:0] value,
                                              logic [SpcPortW-1:0] cnt);
    stack_reply_t r;
    int           len;
    r.status = ST_OK;
    r.rdval  = '0;
    r.len    = '0;
    r.space  = 1'b0;
    if (sid >= NumStacks) begin
      r.status = ST_NO_STACK;
    end else begin
      len = model_len[sid];
      case (mode)
        MODE_PUSH: begin
          if (len >= Depth) begin
            r.status = ST_FULL;
          end else begin
            model_items[len*NumStacks + sid] = value;
            if (len == 0) model_in_use++;
            len++;
          end
        end
        MODE_POP, MODE_PEEK: begin
          if (len == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.rdval = model_items[(len-1)*NumStacks + sid];
            if (mode == MODE_POP) begin
              len--;
              if (len == 0) model_in_use--;
            end
          end
        end
        default: ;
      endcase
      model_len[sid] = len;
      r.len   = len[LenPortW-1:0];
      r.space = (len + int'(cnt) <= Depth);
    end
    r.in_use = model_in_use[UsePortW-1:0];
    return r;
  endfunction

  task automatic add_req(mode_e mode, int sid, logic signed [DataW-1:0] value,
                         int cnt, int gap, bit drain);
    stack_req_t q;
    q.mode  = mode;
    q.sid   = sid[SidPortW-1:0];
    q.value = value;
    q.cnt   = cnt[SpcPortW-1:0];
    q.gap   = gap;
    q.drain = drain;
    request_q.push_back(q);
  endtask

  // style 0: back to back; 1: mostly short gaps; 2: short with some long ones
  function automatic int pick_gap(int style);
    int r;
    r = $urandom_range(0, 99);
    if (style == 0) return 0;
    if (style == 1) return (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                  : $urandom_range(6, 12);
    return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(10, 40);
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    if (r < 8) return {1'b0, {(DataW-1){1'b1}}};
    if (r < 10) return {1'b1, {(DataW-1){1'b0}}};
    return $urandom;
  endfunction

  function automatic int pick_cnt();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(0, Depth)
                                        : $urandom_range(Depth + 1, 31);
  endfunction

  function automatic int pick_sid();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, NumStacks - 1)
                                        : $urandom_range(NumStacks, 15);
  endfunction

  function automatic mode_e pick_mode(int p_push, int p_pop, int p_peek);
    int r;
    r = $urandom_range(0, 99);
    if (r < p_push) return MODE_PUSH;
    if (r < p_push + p_pop) return MODE_POP;
    if (r < p_push + p_pop + p_peek) return MODE_PEEK;
    return MODE_STATUS;
  endfunction

  task automatic check_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      if (fail_count < 10)
        $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  // Driver: present the head request once its gap has elapsed; a drain
  // request also waits until all outstanding results are back.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && busy_o) begin
        // beat not taken yet, hold it
      end else if (request_q.size() != 0 && idle_run >= request_q[0].gap &&
                   !(request_q[0].drain && (replies_due.size() != 0 || start_i))) begin
        drive_req     = request_q.pop_front();
        start_i       <= 1'b1;
        mode_i        <= drive_req.mode;
        stack_id_i    <= drive_req.sid;
        push_value_i  <= drive_req.value;
        space_count_i <= drive_req.cnt;
        idle_run      <= 0;
      end else begin
        start_i  <= 1'b0;
        idle_run <= idle_run + 1;
      end
    end
  end

  // Monitor: model each accepted request, then check any result strobe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        replies_due.push_back(stack_step(mode_e'(mode_i), stack_id_i, push_value_i,
                                         space_count_i));
      if (done_o === 1'b1) begin
        if (replies_due.size() == 0) begin
          if (fail_count < 10) $display("%0t result with nothing pending", $realtime);
          fail_count++;
        end else begin
          due_reply = replies_due.pop_front();
          check_field("status", DataW'(due_reply.status), DataW'(status_o));
          check_field("read_value", due_reply.rdval, read_value_o);
          check_field("stack_length", DataW'(due_reply.len), DataW'(stack_length_o));
          check_field("space_ok", DataW'(due_reply.space), DataW'(space_ok_o));
          check_field("stacks_in_use", DataW'(due_reply.in_use), DataW'(stacks_in_use_o));
        end
      end
    end
  end

  // Watchdog on cycles without any beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int kind;
    int seg_len;
    int style;
    int sid;
    bit drain;
    fail_count   = 0;
    idle_run     = 0;
    quiet_cycles = 0;
    model_in_use = 0;
    foreach (model_items[i]) model_items[i] = '0;
    foreach (model_len[i]) model_len[i] = 0;

    // Directed: space query extremes, empty stack, bad ids, value extremes
    add_req(MODE_STATUS, 0, '0, 0, 0, 0);
    add_req(MODE_STATUS, 0, '0, 16, 0, 0);
    add_req(MODE_STATUS, 0, '0, 31, 1, 0);
    add_req(MODE_POP, 3, '0, 0, 0, 0);
    add_req(MODE_PEEK, 3, '0, 0, 0, 0);
    add_req(MODE_PUSH, 8, 32'sd1, 0, 0, 0);
    add_req(MODE_POP, 15, '0, 0, 2, 0);
    add_req(MODE_PEEK, 9, '0, 0, 0, 0);
    add_req(MODE_STATUS, 12, '0, 5, 0, 0);
    add_req(MODE_PUSH, 7, {1'b0, {(DataW-1){1'b1}}}, 0, 0, 0);
    add_req(MODE_PUSH, 7, {1'b1, {(DataW-1){1'b0}}}, 0, 0, 0);
    add_req(MODE_PEEK, 7, '0, 17, 0, 0);
    add_req(MODE_POP, 7, '0, 15, 0, 0);
    add_req(MODE_PUSH, 0, '1, 31, 3, 0);
    add_req(MODE_PUSH, 0, '0, 0, 0, 0);
    add_req(MODE_PUSH, 1, 32'h5555_5555, 0, 0, 0);
    add_req(MODE_PUSH, 2, 32'haaaa_aaaa, 0, 0, 0);
    add_req(MODE_STATUS, 0, '0, 14, 0, 0);
    add_req(MODE_STATUS, 0, '0, 15, 0, 0);
    add_req(MODE_POP, 7, '0, 0, 0, 0);
    add_req(MODE_POP, 7, '0, 0, 0, 0);
    add_req(MODE_PEEK, 0, '0, 0, 0, 0);
    add_req(MODE_POP, 0, '0, 0, 0, 0);
    add_req(MODE_POP, 0, '0, 0, 1, 0);

    // Random segments: bias the mode mix so stacks fill, drain and go full
    beats_made = 0;
    while (beats_made < RandomBeats) begin
      kind  = $urandom_range(0, 4);
      style = $urandom_range(0, 2);
      drain = (beats_made == 0) || ($urandom_range(0, 3) == 0);
      sid   = $urandom_range(0, NumStacks - 1);
      if (kind == 2 || kind == 3) begin
        for (int i = 0; i < Depth + 2; i++) begin
          add_req((kind == 2) ? MODE_PUSH : MODE_POP, sid, pick_value(), pick_cnt(),
                  pick_gap(style), drain && i == 0);
        end
        add_req((kind == 2) ? MODE_STATUS : MODE_PEEK, sid, pick_value(), pick_cnt(),
                pick_gap(style), 0);
        beats_made += Depth + 3;
      end else begin
        seg_len = $urandom_range(20, 50);
        for (int i = 0; i < seg_len; i++) begin
          add_req((kind == 0) ? pick_mode(65, 15, 10) :
                  (kind == 1) ? pick_mode(20, 55, 15) : pick_mode(25, 25, 25),
                  pick_sid(), pick_value(), pick_cnt(), pick_gap(style), drain && i == 0);
        end
        beats_made += seg_len;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (request_q.size() != 0 || start_i || replies_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && replies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ims_pkg.sv
rtl/ims_store.sv
rtl/interleaved_multi_stack_core.sv
bench/interleaved_multi_stack_core_test.sv
